/* hw/rtl/fbfe_pkg.sv */
// Shared types, command codes and clipping helper for the framebuffer fill engine.
package fbfe_pkg;

	// Command codes carried in the opcode field
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Coordinate and color widths fixed by the command format
	localparam int COORD_W = 7;
	localparam int COLOR_W = 3;

	// Reset value of both size registers
	localparam logic [COORD_W-1:0] SIZE_RESET = 7'd64;

	// One clipped axis of a rectangle
	typedef struct packed {
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		logic               empty;
	} span_t;

	// Sweep request from the command logic to the raster counter
	typedef struct packed {
		logic               start;
		logic [COORD_W-1:0] lo_x;
		logic [COORD_W-1:0] hi_x;
		logic [COORD_W-1:0] lo_y;
		logic [COORD_W-1:0] hi_y;
		logic [COLOR_W-1:0] color;
	} sweep_cmd_t;

	// Raster counter status back to the command logic
	typedef struct packed {
		logic               busy;
		logic               last;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [COLOR_W-1:0] color;
	} sweep_stat_t;

	// Clip the span [org, org + len) against [0, lim)
	function automatic span_t clip_span(input logic [7:0] org, input logic [7:0] len,
			input logic [COORD_W-1:0] lim);
		logic signed [9:0] lo_s;
		logic signed [9:0] hi_s;
		logic signed [9:0] lim_s;
		span_t             s;
		lo_s  = org[7] ? 10'sd0 : signed'({3'b000, org[6:0]});
		hi_s  = signed'({{2{org[7]}}, org}) + signed'({2'b00, len});
		lim_s = signed'({3'b000, lim});
		if (hi_s > lim_s) begin
			hi_s = lim_s;
		end
		s.lo    = lo_s[COORD_W-1:0];
		s.hi    = hi_s[COORD_W-1:0];
		s.empty = (hi_s <= lo_s);
		return s;
	endfunction

endpackage

/* hw/rtl/fbfe_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module fbfe_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/fbfe_raster.sv */
// Raster counter that walks a clipped rectangle one pixel per cycle.
module fbfe_raster (
	input  logic                clk,
	input  logic                arst_n,
	input  fbfe_pkg::sweep_cmd_t cmd,
	output fbfe_pkg::sweep_stat_t stat
);
	import fbfe_pkg::*;

	logic               busy_q;
	logic [COORD_W-1:0] fill_column_q;
	logic [COORD_W-1:0] fill_row_q;
	logic [COORD_W-1:0] lo_x_q;
	logic [COORD_W-1:0] hi_x_q;
	logic [COORD_W-1:0] hi_y_q;
	logic [COLOR_W-1:0] color_q;
	logic               col_last;
	logic               row_last;

	assign col_last = (fill_column_q == hi_x_q - 7'd1);
	assign row_last = (fill_row_q == hi_y_q - 7'd1);

	// Advance column, wrap to the next row, drop busy after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			fill_column_q <= '0;
			fill_row_q    <= '0;
		end else if (cmd.start) begin
			busy_q        <= 1'b1;
			fill_column_q <= cmd.lo_x;
			fill_row_q    <= cmd.lo_y;
		end else if (busy_q) begin
			if (col_last) begin
				if (row_last) begin
					busy_q        <= 1'b0;
					fill_column_q <= '0;
					fill_row_q    <= '0;
				end else begin
					fill_column_q <= lo_x_q;
					fill_row_q    <= fill_row_q + 7'd1;
				end
			end else begin
				fill_column_q <= fill_column_q + 7'd1;
			end
		end
	end

	// Hold rectangle bounds and color for the sweep
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_x_q  <= cmd.lo_x;
			hi_x_q  <= cmd.hi_x;
			hi_y_q  <= cmd.hi_y;
			color_q <= cmd.color;
		end
	end

	assign stat.busy  = busy_q;
	assign stat.last  = busy_q & col_last & row_last;
	assign stat.col   = fill_column_q;
	assign stat.row   = fill_row_q;
	assign stat.color = color_q;

endmodule

/* hw/rtl/framebuffer_fill_engine.sv */
// Top level of the framebuffer fill engine: command decode, memory port and result register.
//
//  Channel   Signals                          Moves
//  command   s_tvalid s_tready s_tdata[31:0]  one command per transfer
//  result    m_tvalid m_tready m_tdata[7:0]   one result per command
//  config    cfg_we cfg_addr cfg_wdata[6:0]   register write, no handshake
//
//  A pixel write goes straight to memory; a pixel read passes through ST_READ for its
//  one frame memory read. A fill square or clear that is not clipped empty holds ST_FILL
//  while the single memory write port paints one pixel per cycle, with s_tready low.
//  After reset a clearing pass writes black to all MAX_WIDTH*MAX_HEIGHT entries,
//  one per cycle (4096 entries at default size), with s_tready low.
//  A command is taken in the cycle the previous result transfers; a result that
//  waits on m_tready holds s_tready low.
module framebuffer_fill_engine #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0], x_coord[9:2], y_coord[17:10], square_size[25:18],
	// pixel_color[28:26], zero[31:29]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_color[2:0], in_bounds[3], zero[7:4]
	output logic [7:0]  m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [6:0]  cfg_wdata
);
	import fbfe_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] STRIDE    = AW'(MAX_WIDTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [COORD_W-1:0] WCAP = (MAX_WIDTH > 127) ? 7'd127 : COORD_W'(MAX_WIDTH);
	localparam logic [COORD_W-1:0] HCAP = (MAX_HEIGHT > 127) ? 7'd127 : COORD_W'(MAX_HEIGHT);

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_FILL = 2'd3;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	logic [1:0]         state_q;
	logic [AW-1:0]      init_addr_q;
	logic [COORD_W-1:0] width_q;
	logic [COORD_W-1:0] height_q;
	logic [COORD_W-1:0] eff_w;
	logic [COORD_W-1:0] eff_h;
	logic               m_tvalid_q;
	logic [7:0]         m_tdata_q;
	logic               rd_ib_q;

	logic [1:0]         op;
	logic [7:0]         x_in;
	logic [7:0]         y_in;
	logic [7:0]         size_in;
	logic [COLOR_W-1:0] color_in;
	logic               accept;
	logic               ib;
	logic               sweep_op;
	logic               sweep_empty;
	span_t              span_x;
	span_t              span_y;
	sweep_cmd_t         cmd;
	sweep_stat_t        stat;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [COLOR_W-1:0] mem_wdata;
	logic [AW-1:0]      pix_addr;
	logic [COLOR_W-1:0] mem_rdata;

	// Unpack command fields
	assign op       = s_tdata[1:0];
	assign x_in     = s_tdata[9:2];
	assign y_in     = s_tdata[17:10];
	assign size_in  = s_tdata[25:18];
	assign color_in = s_tdata[28:26];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_WIDTH:  width_q  <= cfg_wdata;
				CFG_HEIGHT: height_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	assign eff_w = (width_q < WCAP) ? width_q : WCAP;
	assign eff_h = (height_q < HCAP) ? height_q : HCAP;

	// Bounds check and addressing of a single pixel
	assign ib = !x_in[7] && (x_in[6:0] < eff_w) && !y_in[7] && (y_in[6:0] < eff_h);
	assign pix_addr = AW'(y_in[6:0]) * STRIDE + AW'(x_in[6:0]);

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// Clip the fill rectangle, or take the whole active area for clear
	always_comb begin
		span_x = clip_span(x_in, size_in, eff_w);
		span_y = clip_span(y_in, size_in, eff_h);
		if (op == OP_CLEAR) begin
			span_x.lo    = '0;
			span_x.hi    = eff_w;
			span_x.empty = (eff_w == '0);
			span_y.lo    = '0;
			span_y.hi    = eff_h;
			span_y.empty = (eff_h == '0);
		end
	end

	assign sweep_op    = (op == OP_FILL) || (op == OP_CLEAR);
	assign sweep_empty = span_x.empty || span_y.empty;

	assign cmd.start = accept && sweep_op && !sweep_empty;
	assign cmd.lo_x  = span_x.lo;
	assign cmd.hi_x  = span_x.hi;
	assign cmd.lo_y  = span_y.lo;
	assign cmd.hi_y  = span_y.hi;
	assign cmd.color = color_in;

	fbfe_raster u_raster (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Select the memory write: clearing pass, raster sweep or pixel write
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pix_addr;
		mem_wdata = color_in;
		if (state_q == ST_INIT) begin
			mem_we    = 1'b1;
			mem_waddr = init_addr_q;
			mem_wdata = '0;
		end else if (stat.busy) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(stat.row) * STRIDE + AW'(stat.col);
			mem_wdata = stat.color;
		end else if (accept && (op == OP_WRITE) && ib) begin
			mem_we = 1'b1;
		end
	end

	fbfe_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (pix_addr),
		.rdata (mem_rdata)
	);

	// Command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_addr_q <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					init_addr_q <= init_addr_q + 1'b1;
					if (init_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (op == OP_READ)) begin
						state_q <= ST_READ;
					end else if (cmd.start) begin
						state_q <= ST_FILL;
					end
				end
				ST_READ: state_q <= ST_IDLE;
				ST_FILL: begin
					if (stat.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold in-bounds flag of a pending read
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ib_q <= ib;
		end
	end

	// Result register: load on command or read return, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((accept && (op != OP_READ)) || (state_q == ST_READ)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			m_tdata_q <= {4'b0000, rd_ib_q, rd_ib_q ? mem_rdata : 3'b000};
		end else if (accept) begin
			m_tdata_q <= {4'b0000, (op == OP_CLEAR) ? 1'b1 : ib, 3'b000};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* bench/tb_framebuffer_fill_engine.sv */
// Self-checking stream testbench for the framebuffer fill engine with a shadow frame predictor.
module tb_framebuffer_fill_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import fbfe_pkg::*;

	localparam int FB_W        = 64;
	localparam int FB_H        = 64;
	localparam int NUM_PHASES  = 10;
	localparam int CYCLE_LIMIT = 40000000;

	// Register indexes on cfg_addr
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Result word: read_color[2:0], in_bounds[3], pad[7:4]
	typedef struct packed {
		logic [3:0]         pad;
		logic               in_bounds;
		logic [COLOR_W-1:0] read_color;
	} result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	// opcode[1:0], x_coord[9:2], y_coord[17:10], square_size[25:18], pixel_color[28:26]
	logic [31:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// read_color[2:0], in_bounds[3]
	logic [7:0]  m_tdata;
	logic        cfg_we    = 1'b0;
	logic        cfg_addr  = REG_WIDTH;
	logic [6:0]  cfg_wdata = '0;

	// Shadow copy of the frame and the size registers
	logic [COLOR_W-1:0] shadow_frame [FB_W*FB_H];
	logic [6:0]         width_reg  = SIZE_RESET;
	logic [6:0]         height_reg = SIZE_RESET;

	logic [31:0] cmd_queue [$];
	result_t     expected_results [$];
	result_t     want;
	result_t     got;
	int          errors      = 0;
	int          send_gap    = 0;
	int          recv_gap    = 0;
	int          cycle_count = 0;
	bit          gaps_on     = 1'b1;

	framebuffer_fill_engine #(
		.MAX_WIDTH (FB_W),
		.MAX_HEIGHT(FB_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Clamp the size registers to the storage size
	function automatic int eff_w();
		return (width_reg < FB_W) ? int'(width_reg) : FB_W;
	endfunction

	function automatic int eff_h();
		return (height_reg < FB_H) ? int'(height_reg) : FB_H;
	endfunction

	function automatic bit on_screen(input int x, input int y);
		return x >= 0 && x < eff_w() && y >= 0 && y < eff_h();
	endfunction

	// Paint [x0,x1) x [y0,y1) clipped to the active display
	function automatic void paint_area(input int x0, input int y0, input int x1, input int y1,
			input logic [COLOR_W-1:0] color);
		int lo_x;
		int lo_y;
		int hi_x;
		int hi_y;
		lo_x = (x0 < 0) ? 0 : x0;
		lo_y = (y0 < 0) ? 0 : y0;
		hi_x = (x1 > eff_w()) ? eff_w() : x1;
		hi_y = (y1 > eff_h()) ? eff_h() : y1;
		for (int y = lo_y; y < hi_y; y++) begin
			for (int x = lo_x; x < hi_x; x++) begin
				shadow_frame[y*FB_W + x] = color;
			end
		end
	endfunction

	// Update the shadow frame for one command and queue its result
	function automatic void apply_command(input logic [31:0] word);
		logic [1:0]         op;
		logic signed [7:0]  xs;
		logic signed [7:0]  ys;
		logic [COLOR_W-1:0] color;
		int                 x;
		int                 y;
		int                 edge_len;
		result_t            r;
		op       = word[1:0];
		xs       = word[9:2];
		ys       = word[17:10];
		edge_len = word[25:18];
		color    = word[28:26];
		x        = xs;
		y        = ys;
		r        = '0;
		r.in_bounds = on_screen(x, y);
		case (op)
			OP_WRITE: begin
				if (r.in_bounds) shadow_frame[y*FB_W + x] = color;
			end
			OP_READ: begin
				if (r.in_bounds) r.read_color = shadow_frame[y*FB_W + x];
			end
			OP_FILL: begin
				paint_area(x, y, x + edge_len, y + edge_len, color);
			end
			default: begin
				paint_area(0, 0, eff_w(), eff_h(), color);
				r.in_bounds = 1'b1;
			end
		endcase
		expected_results.push_back(r);
	endfunction

	function automatic logic [31:0] pack_cmd(input logic [1:0] op, input int x, input int y,
			input int edge_len, input int color);
		logic [7:0] xb;
		logic [7:0] yb;
		logic [7:0] sb;
		logic [2:0] cb;
		xb = x[7:0];
		yb = y[7:0];
		sb = edge_len[7:0];
		cb = color[2:0];
		return {3'b000, cb, sb, yb, xb, op};
	endfunction

	// Mostly on-screen commands, small squares and rare clears
	function automatic logic [31:0] random_cmd();
		int         r;
		int         ew;
		int         eh;
		int         x;
		int         y;
		int         edge_len;
		logic [1:0] op;
		r  = $urandom_range(0, 99);
		op = (r < 40) ? OP_WRITE : (r < 80) ? OP_READ : (r < 98) ? OP_FILL : OP_CLEAR;
		ew = eff_w();
		eh = eff_h();
		if ($urandom_range(0, 9) < 8 && ew > 0 && eh > 0) begin
			x = $urandom_range(0, ew - 1);
			y = $urandom_range(0, eh - 1);
			if (op == OP_FILL) begin
				x = x - $urandom_range(0, 4);
				y = y - $urandom_range(0, 4);
			end
		end else begin
			x = $urandom_range(0, 255) - 128;
			y = $urandom_range(0, 255) - 128;
		end
		edge_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 128) : $urandom_range(0, 8);
		return pack_cmd(op, x, y, edge_len, $urandom_range(0, 7));
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int draw_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Hold until every command is taken and every result has come back
	task automatic wait_idle();
		do @(posedge clk);
		while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0 ||
				s_tready !== 1'b1);
		repeat (8) @(posedge clk);
	endtask

	// Command driver: predict on each transfer, then present the next command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) apply_command(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (cmd_queue.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= cmd_queue.pop_front();
					send_gap <= draw_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					$display("%0t: result %h with no command outstanding", $time, m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.read_color !== want.read_color) begin
						$display("%0t: read_color expected %0d actual %0d",
							$time, want.read_color, got.read_color);
						errors++;
					end
					if (got.in_bounds !== want.in_bounds) begin
						$display("%0t: in_bounds expected %0d actual %0d",
							$time, want.in_bounds, got.in_bounds);
						errors++;
					end
					if (got.pad !== want.pad) begin
						$display("%0t: pad bits expected %h actual %h", $time, want.pad, got.pad);
						errors++;
					end
				end
			end
			if (recv_gap > 0) begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1'b1;
				recv_gap <= draw_gap();
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Phase sequencer: size registers, then commands for that geometry
	initial begin
		int w;
		int h;
		int phase_w [NUM_PHASES];
		int phase_h [NUM_PHASES];
		int phase_items [NUM_PHASES];
		phase_w     = '{64, 1, 64, 1, 0, 23, 127, 0, 0, 0};
		phase_h     = '{64, 1, 1, 64, 37, 0, 90, 0, 0, 0};
		phase_items = '{300, 100, 150, 150, 60, 60, 150, 230, 230, 230};
		for (int i = 0; i < FB_W*FB_H; i++) shadow_frame[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			w = (p >= 7) ? $urandom_range(1, 64) : phase_w[p];
			h = (p >= 7) ? $urandom_range(1, 64) : phase_h[p];
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_addr  <= REG_WIDTH;
			cfg_wdata <= w[6:0];
			@(posedge clk);
			cfg_addr  <= REG_HEIGHT;
			cfg_wdata <= h[6:0];
			@(posedge clk);
			cfg_we    <= 1'b0;
			width_reg  = w[6:0];
			height_reg = h[6:0];
			gaps_on    = ($urandom_range(0, 3) != 0);
			if (p == 0) begin
				// Corners, off-screen pixels, clipped and empty squares, clear
				cmd_queue.push_back(pack_cmd(OP_WRITE, 0, 0, 0, 7));
				cmd_queue.push_back(pack_cmd(OP_READ, 0, 0, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_WRITE, 63, 63, 0, 5));
				cmd_queue.push_back(pack_cmd(OP_READ, 63, 63, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_WRITE, -1, 0, 0, 3));
				cmd_queue.push_back(pack_cmd(OP_WRITE, 64, 5, 0, 3));
				cmd_queue.push_back(pack_cmd(OP_WRITE, 5, -128, 0, 3));
				cmd_queue.push_back(pack_cmd(OP_WRITE, 127, 127, 128, 7));
				cmd_queue.push_back(pack_cmd(OP_READ, -128, -128, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_READ, 127, 0, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_READ, 0, 64, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_FILL, -3, -3, 6, 2));
				cmd_queue.push_back(pack_cmd(OP_READ, 2, 2, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_READ, 3, 3, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_FILL, 60, 60, 128, 6));
				cmd_queue.push_back(pack_cmd(OP_READ, 63, 63, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_FILL, 10, 10, 0, 1));
				cmd_queue.push_back(pack_cmd(OP_READ, 10, 10, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_FILL, -128, -128, 128, 4));
				cmd_queue.push_back(pack_cmd(OP_READ, 0, 0, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_CLEAR, 0, 0, 0, 1));
				cmd_queue.push_back(pack_cmd(OP_READ, 32, 32, 0, 0));
				cmd_queue.push_back(pack_cmd(OP_READ, 0, 63, 0, 0));
			end
			repeat (phase_items[p]) cmd_queue.push_back(random_cmd());
		end
		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
